/* hdl/windowed_nearest_point_search_core_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the windowed nearest point search core
// Shared property wrappers, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef WINDOWED_NEAREST_POINT_SEARCH_CORE_ASSERT_SVH
`define WINDOWED_NEAREST_POINT_SEARCH_CORE_ASSERT_SVH

// Same-cycle implication.
`define WNPS_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define WNPS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/wnps_pkg.sv */
// ----------------------------------------------------------------------------
// wnps_pkg
// Types and fixed codes shared by the windowed nearest point search core.
// ----------------------------------------------------------------------------
`default_nettype none

package wnps_pkg;

	// Widest coordinate that the core supports.
	localparam int CoordMax = 24;

	// Half window used when the search window register is zero.
	localparam int DefaultWindow = 24;

	// Command codes.
	localparam logic [1:0] CMD_CLEAR    = 2'd0;
	localparam logic [1:0] CMD_WRITE    = 2'd1;
	localparam logic [1:0] CMD_REGISTER = 2'd2;
	localparam logic [1:0] CMD_QUERY    = 2'd3;

	// Result status codes.
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_BAD_COUNT = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;
	localparam logic [1:0] ST_INVALID   = 2'd3;

	// Configuration register indexes.
	localparam logic CFG_SEARCH_WINDOW = 1'b0;
	localparam logic CFG_LOOK_AHEAD    = 1'b1;

	// One classified command as it sits in the queue.
	typedef struct packed {
		logic [1:0]                 cmd;
		logic [3:0]                 route;
		logic [7:0]                 node;
		logic                       node_ok;
		logic [8:0]                 count;
		logic                       bad_count;
		logic signed [CoordMax-1:0] x;
		logic signed [CoordMax-1:0] y;
		logic signed [CoordMax-1:0] z;
		logic signed [8:0]          hint;
	} wnps_item_t;

endpackage

`default_nettype wire

/* hdl/wnps_front.sv */
// ----------------------------------------------------------------------------
// wnps_front
// Accepts command beats, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none
`include "windowed_nearest_point_search_core_assert.svh"

module wnps_front import wnps_pkg::*; #(
	parameter int MAX_POINTS = 256,
	parameter int COORD_BITS = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [1:0]        cmd,
	input  wire logic [3:0]        route_index,
	input  wire logic [7:0]        node_index,
	input  wire logic [8:0]        node_count,
	input  wire logic signed [15:0] point_x,
	input  wire logic signed [15:0] point_y,
	input  wire logic signed [15:0] point_z,
	input  wire logic signed [8:0] hint_index,
	output logic                   item_valid,
	output wnps_item_t             item,
	input  wire logic              item_pop
);

	wnps_item_t           fifo_q [2];
	logic                 wr_ptr_q;
	logic                 rd_ptr_q;
	logic [1:0]           count_q;
	logic                 push;
	wnps_item_t           cls;
	logic [CoordMax-1:0]  ex, ey, ez;

	// Coordinates keep their low COORD_BITS bits, sign extended.
	always_comb begin
		ex = CoordMax'(point_x);
		ey = CoordMax'(point_y);
		ez = CoordMax'(point_z);
		cls.cmd       = cmd;
		cls.route     = route_index;
		cls.node      = node_index;
		cls.node_ok   = 32'(node_index) < 32'(MAX_POINTS);
		cls.count     = node_count;
		cls.bad_count = (node_count == 9'd0) || (32'(node_count) > 32'(MAX_POINTS));
		cls.x         = CoordMax'(signed'(ex[COORD_BITS-1:0]));
		cls.y         = CoordMax'(signed'(ey[COORD_BITS-1:0]));
		cls.z         = CoordMax'(signed'(ez[COORD_BITS-1:0]));
		cls.hint      = hint_index;
	end

	assign in_ready   = (count_q != 2'd2);
	assign push       = in_valid && in_ready;
	assign item_valid = (count_q != 2'd0);
	assign item       = fifo_q[rd_ptr_q];

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= cls;
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (item_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !item_pop) begin
				count_q <= count_q + 2'd1;
			end else if (!push && item_pop) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	`WNPS_ASSERT_IMPL(a_fill_bound, 1'b1, count_q <= 2'd2, "queue overfilled")
	`WNPS_ASSERT_IMPL(a_pop_nonempty, item_pop, count_q != 2'd0, "pop from empty queue")
	`WNPS_ASSERT_NEXT(a_push_counts, push && !item_pop, count_q == $past(count_q) + 2'd1, "push lost")

endmodule

`default_nettype wire

/* hdl/wnps_back.sv */
// ----------------------------------------------------------------------------
// wnps_back
// Executes queued commands: route table upkeep, point store writes and the
// pipelined nearest point scan, with a registered result stage.
// ----------------------------------------------------------------------------
`default_nettype none
`include "windowed_nearest_point_search_core_assert.svh"

module wnps_back import wnps_pkg::*; #(
	parameter int MAX_ROUTES = 16,
	parameter int MAX_POINTS = 256,
	parameter int COORD_BITS = 16
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       item_valid,
	input  wire wnps_item_t item,
	output logic            item_pop,
	input  wire logic [7:0] search_window,
	input  wire logic [7:0] look_ahead,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [1:0]      status,
	output logic [3:0]      assigned_route,
	output logic [7:0]      closest_index,
	output logic [7:0]      target_index
);

	localparam int RB    = (MAX_ROUTES > 1) ? $clog2(MAX_ROUTES) : 1;
	localparam int UB    = $clog2(MAX_ROUTES + 1);
	localparam int PB    = $clog2(MAX_POINTS);
	localparam int LB    = $clog2(MAX_POINTS + 1);
	localparam int DEPTH = MAX_ROUTES * MAX_POINTS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CB    = COORD_BITS;
	localparam int MW    = 3 * CB;
	localparam int SQW   = 2 * CB;
	localparam int DW    = SQW + 2;
	localparam int SW    = ((LB > 9) ? LB : 9) + 2;
	localparam int TW    = ((LB > 8) ? LB : 8) + 1;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_SETUP = 2'd1;
	localparam logic [1:0] S_SCAN  = 2'd2;
	localparam logic [1:0] S_DRAIN = 2'd3;

	logic [1:0]           state_q;
	logic [UB-1:0]        routes_used_q;
	logic                 rvalid_q [MAX_ROUTES];
	logic [LB-1:0]        rlen_q   [MAX_ROUTES];

	logic [RB-1:0]        qroute_q;
	logic signed [CB-1:0] qc_q [3];
	logic signed [8:0]    qhint_q;
	logic [LB-1:0]        qlen_q;
	logic [PB-1:0]        idx_q;
	logic [PB-1:0]        hi_q;

	logic [MW-1:0]        mem [DEPTH];
	logic [MW-1:0]        rd_s1;
	logic                 vld_s1;
	logic [PB-1:0]        idx_s1;
	logic [SQW-1:0]       sq_s2 [3];
	logic                 vld_s2;
	logic [PB-1:0]        idx_s2;
	logic [DW-1:0]        best_q;
	logic [PB-1:0]        closest_q;
	logic                 have_q;

	logic                 out_free;
	logic                 full;
	logic [RB-1:0]        slot;
	logic [RB-1:0]        rsel;
	logic                 route_ok;
	logic                 mem_we;
	logic [AW-1:0]        waddr;
	logic [AW-1:0]        raddr;

	logic                 res_we;
	logic [1:0]           res_status;
	logic [3:0]           res_assigned;
	logic [7:0]           res_closest;
	logic [7:0]           res_target;

	logic [8:0]           win9;
	logic signed [SW-1:0] hint_s, len_s, win_s, lo_s, hi_s, lenm1_s, lo_sel, hi_sel;
	logic                 hint_ok;
	logic [TW-1:0]        tsum, tlast, tsel;
	logic signed [CB:0]   diff [3];
	logic [CB-1:0]        mag  [3];
	logic [DW-1:0]        dsum;

	assign out_free = !out_valid || out_ready;
	assign full     = (routes_used_q == UB'(MAX_ROUTES));
	assign slot     = RB'(routes_used_q);
	assign rsel     = RB'(item.route);
	assign route_ok = (32'(item.route) < 32'(routes_used_q)) &&
		(32'(item.route) < 32'(MAX_ROUTES)) && rvalid_q[rsel] &&
		(rlen_q[rsel] != '0) && (32'(rlen_q[rsel]) <= 32'(MAX_POINTS));
	assign item_pop = item_valid && (state_q == S_IDLE) && out_free;
	assign mem_we   = item_pop && (item.cmd == CMD_WRITE) && !full && item.node_ok;
	assign waddr    = AW'(32'(slot) * 32'(MAX_POINTS) + 32'(item.node));
	assign raddr    = AW'(32'(qroute_q) * 32'(MAX_POINTS) + 32'(idx_q));

	// Scan bounds from the hint and window.
	always_comb begin
		win9    = (search_window == 8'd0) ? 9'(DefaultWindow) : {1'b0, search_window};
		hint_s  = SW'(qhint_q);
		len_s   = signed'(SW'(qlen_q));
		win_s   = signed'(SW'(win9));
		lenm1_s = len_s - SW'(1);
		lo_s    = hint_s - win_s;
		hi_s    = hint_s + win_s;
		hint_ok = (hint_s >= 0) && (hint_s < len_s);
		lo_sel  = '0;
		hi_sel  = lenm1_s;
		if (hint_ok) begin
			lo_sel = (lo_s < 0) ? SW'(0) : lo_s;
			hi_sel = (hi_s > lenm1_s) ? lenm1_s : hi_s;
		end
	end

	// Target index: nearest plus look-ahead, clamped to the last point.
	always_comb begin
		tsum  = TW'(closest_q) + TW'(look_ahead);
		tlast = TW'(qlen_q) - TW'(1);
		tsel  = (tsum > tlast) ? tlast : tsum;
	end

	// Result selection for the command being finished.
	always_comb begin
		res_we       = 1'b0;
		res_status   = ST_OK;
		res_assigned = 4'd0;
		res_closest  = 8'd0;
		res_target   = 8'd0;
		if (item_pop) begin
			case (item.cmd)
				CMD_CLEAR: begin
					res_we = 1'b1;
				end
				CMD_WRITE: begin
					res_we     = 1'b1;
					res_status = full ? ST_FULL : ST_OK;
				end
				CMD_REGISTER: begin
					res_we = 1'b1;
					if (item.bad_count) begin
						res_status = ST_BAD_COUNT;
					end else if (full) begin
						res_status = ST_FULL;
					end else begin
						res_assigned = 4'(slot);
					end
				end
				default: begin
					if (!route_ok) begin
						res_we     = 1'b1;
						res_status = ST_INVALID;
					end
				end
			endcase
		end else if ((state_q == S_DRAIN) && !vld_s1 && !vld_s2 && out_free) begin
			res_we      = 1'b1;
			res_closest = 8'(closest_q);
			res_target  = 8'(tsel);
		end
	end

	// Sequencer, route table and scan pipeline valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			routes_used_q <= '0;
			for (int r = 0; r < MAX_ROUTES; r++) begin
				rvalid_q[r] <= 1'b0;
				rlen_q[r]   <= '0;
			end
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			have_q <= 1'b0;
		end else begin
			vld_s1 <= (state_q == S_SCAN);
			vld_s2 <= vld_s1;
			if (vld_s2 && (!have_q || dsum < best_q)) begin
				have_q <= 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (item_pop) begin
						case (item.cmd)
							CMD_CLEAR: begin
								routes_used_q <= '0;
								for (int r = 0; r < MAX_ROUTES; r++) begin
									rvalid_q[r] <= 1'b0;
									rlen_q[r]   <= '0;
								end
							end
							CMD_REGISTER: begin
								if (!item.bad_count && !full) begin
									rlen_q[slot]   <= LB'(item.count);
									rvalid_q[slot] <= 1'b1;
									routes_used_q  <= routes_used_q + UB'(1);
								end
							end
							CMD_QUERY: begin
								if (route_ok) begin
									state_q <= S_SETUP;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_SETUP: begin
					have_q  <= 1'b0;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (idx_q == hi_q) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (res_we) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Query context and scan index.
	always_ff @(posedge clk) begin
		if (item_pop) begin
			qroute_q <= rsel;
			qc_q[0]  <= CB'(item.x);
			qc_q[1]  <= CB'(item.y);
			qc_q[2]  <= CB'(item.z);
			qhint_q  <= item.hint;
			qlen_q   <= rlen_q[rsel];
		end
		if (state_q == S_SETUP) begin
			idx_q <= PB'(lo_sel);
			hi_q  <= PB'(hi_sel);
		end else if (state_q == S_SCAN) begin
			idx_q <= idx_q + PB'(1);
		end
		idx_s1 <= idx_q;
		idx_s2 <= idx_s1;
	end

	// Point store: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= {CB'(item.z), CB'(item.y), CB'(item.x)};
		end
		rd_s1 <= mem[raddr];
	end

	// Per-axis absolute differences and the sum of the squared differences.
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			diff[k] = (CB+1)'(signed'(rd_s1[k*CB +: CB])) - (CB+1)'(qc_q[k]);
			mag[k]  = diff[k][CB] ? CB'(-diff[k]) : CB'(diff[k]);
		end
		dsum = DW'(sq_s2[0]) + DW'(sq_s2[1]) + DW'(sq_s2[2]);
	end

	// Squares, then sum and keep the first minimum.
	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			sq_s2[k] <= SQW'(mag[k]) * SQW'(mag[k]);
		end
		if (vld_s2 && (!have_q || dsum < best_q)) begin
			best_q    <= dsum;
			closest_q <= idx_s2;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (res_we) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_we) begin
			status         <= res_status;
			assigned_route <= res_assigned;
			closest_index  <= res_closest;
			target_index   <= res_target;
		end
	end

	`WNPS_ASSERT_IMPL(a_used_bound, 1'b1, routes_used_q <= UB'(MAX_ROUTES), "route count overflow")
	`WNPS_ASSERT_IMPL(a_pipe_state, vld_s1, state_q == S_SCAN || state_q == S_DRAIN, "stray scan beat")
	`WNPS_ASSERT_IMPL(a_scan_bound, state_q == S_SCAN, idx_q <= hi_q, "scan ran past bound")

endmodule

`default_nettype wire

/* hdl/windowed_nearest_point_search_core.sv */
// ----------------------------------------------------------------------------
// windowed_nearest_point_search_core
// Route table of 3D points with windowed nearest point queries.
// ----------------------------------------------------------------------------
// Clear, write and register commands select their result in the same cycle
// in which they leave the queue. A query scans n points: 2 * window + 1 at
// most for a hinted query (49 with the default window of 24), or the whole
// route length when the hint lies outside the route. The scan reads one
// point per cycle from the point store and does not stall.
// A two-entry command queue lets new beats be taken while a query runs.
// The result register holds a finished result until it is taken, and the
// next command starts no earlier than the cycle in which that result is taken.
// The point store needs no clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module windowed_nearest_point_search_core import wnps_pkg::*; #(
	parameter int MAX_ROUTES = 16,
	parameter int MAX_POINTS = 256,
	parameter int COORD_BITS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic               cfg_index,
	input  wire logic [7:0]         cfg_data,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [1:0]         cmd,
	input  wire logic [3:0]         route_index,
	input  wire logic [7:0]         node_index,
	input  wire logic [8:0]         node_count,
	input  wire logic signed [15:0] point_x,
	input  wire logic signed [15:0] point_y,
	input  wire logic signed [15:0] point_z,
	input  wire logic signed [8:0]  hint_index,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [1:0]              status,
	output logic [3:0]              assigned_route,
	output logic [7:0]              closest_index,
	output logic [7:0]              target_index
);

	logic [7:0] window_q;
	logic [7:0] look_q;
	logic       item_valid;
	logic       item_pop;
	wnps_item_t item;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= 8'd0;
			look_q   <= 8'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SEARCH_WINDOW: window_q <= cfg_data;
				CFG_LOOK_AHEAD:    look_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	wnps_front #(
		.MAX_POINTS (MAX_POINTS),
		.COORD_BITS (COORD_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.cmd         (cmd),
		.route_index (route_index),
		.node_index  (node_index),
		.node_count  (node_count),
		.point_x     (point_x),
		.point_y     (point_y),
		.point_z     (point_z),
		.hint_index  (hint_index),
		.item_valid  (item_valid),
		.item        (item),
		.item_pop    (item_pop)
	);

	wnps_back #(
		.MAX_ROUTES (MAX_ROUTES),
		.MAX_POINTS (MAX_POINTS),
		.COORD_BITS (COORD_BITS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (item_valid),
		.item           (item),
		.item_pop       (item_pop),
		.search_window  (window_q),
		.look_ahead     (look_q),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.assigned_route (assigned_route),
		.closest_index  (closest_index),
		.target_index   (target_index)
	);

endmodule

`default_nettype wire
